// ----- sv/lgd_pkg.sv -----
// lgd_pkg: shared types, constants and constant tables for the lorentz distance block
`timescale 1ns / 1ps
package lgd_pkg;

  localparam int MAX_DIM           = 64;
  localparam int CORDIC_ITERATIONS = 32;
  localparam int IDX_W             = $clog2(MAX_DIM + 1);
  localparam int N_W               = $clog2(CORDIC_ITERATIONS);

  localparam logic [63:0] ONE_Q40 = 64'd1 << 40;
  localparam logic [63:0] ONE_Q39 = 64'd1 << 39;
  localparam logic [63:0] ONE_Q38 = 64'd1 << 38;
  localparam logic signed [63:0] ACC_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] ACC_MIN = {1'b1, {63{1'b0}}};

  localparam logic [31:0] INV_SQRT_RST = 32'd16777216;
  localparam logic [19:0] EPS_RST      = 20'd10;

  localparam logic CFG_INV_SQRT = 1'b0;
  localparam logic CFG_EPSILON  = 1'b1;

  typedef struct packed {
    logic signed [31:0] u_coord;
    logic signed [31:0] v_coord;
    logic               last_coord;
  } lgd_in_t;

  typedef struct packed {
    logic [31:0] distance;
    logic        was_clamped;
    logic        saturated;
  } lgd_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sq_stat_t;

  typedef logic [62:0][63:0] atanh_tab_t;

  function automatic logic [63:0] div_odd(input logic [63:0] v, input int k);
    logic [63:0] r;
    unique case (k)
      0: r = v;
      1: r = v / 3;
      2: r = v / 5;
      3: r = v / 7;
      4: r = v / 9;
      5: r = v / 11;
      6: r = v / 13;
      7: r = v / 15;
      8: r = v / 17;
      9: r = v / 19;
      10: r = v / 21;
      11: r = v / 23;
      12: r = v / 25;
      13: r = v / 27;
      14: r = v / 29;
      15: r = v / 31;
      16: r = v / 33;
      17: r = v / 35;
      18: r = v / 37;
      19: r = v / 39;
      20: r = v / 41;
      21: r = v / 43;
      22: r = v / 45;
      23: r = v / 47;
      24: r = v / 49;
      25: r = v / 51;
      26: r = v / 53;
      27: r = v / 55;
      28: r = v / 57;
      29: r = v / 59;
      30: r = v / 61;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic atanh_tab_t build_atanh();
    atanh_tab_t t;
    logic [63:0] acc;
    t = '0;
    for (int i = 1; i < 63; i++) begin
      acc = '0;
      for (int k = 0; k < 31; k++) begin
        if (i * (2 * k + 1) <= 62) begin
          acc = acc + div_odd(64'd1 << (62 - i * (2 * k + 1)), k);
        end
      end
      t[i] = acc;
    end
    return t;
  endfunction

  function automatic logic [63:0] build_ln2();
    logic [63:0] p;
    logic [63:0] sum;
    p = (64'd1 << 62) / 3;
    sum = '0;
    for (int k = 0; k < 31; k++) begin
      if (p != 0) begin
        sum = sum + div_odd(p, k);
        p = p / 9;
      end
    end
    return sum << 1;
  endfunction

  localparam atanh_tab_t  ATANH_TAB = build_atanh();
  localparam logic [63:0] LN2_Q62   = build_ln2();
  localparam logic [31:0] LN2_Q27   = 32'(LN2_Q62 >> 35);

endpackage

// ----- sv/lorentz_geodesic_distance.sv -----
// lorentz_geodesic_distance: top level, sequencer and datapath around shared units
//
// usage
//   in channel: one coordinate pair per request (u, v, last flag), time part first
//   out channel: one result request per vector, on the pair with last_coord set
//   cfg port: plain writes, index 0 inv_sqrt_curvature, index 1 clamp_epsilon
// sequencing
//   a pair without last goes through the shared multiplier, then the accumulate
//   state; a last pair then runs the clamp, two square roots in series on one
//   unit, the octave normalize, the cordic loop and the scaling multiply before
//   the result is offered
//   in_stall is high whenever the sequencer is busy
// reset
//   synchronous active-low reset clears the accumulator, index and output
//   valid and restores both registers to their defaults
// stall
//   the result sits in an output register; if it is not taken, the next
//   result waits in the final state until the register frees
`timescale 1ns / 1ps
module lorentz_geodesic_distance (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lgd_pkg::lgd_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output lgd_pkg::lgd_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data
);
  import lgd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ACC, S_CLAMP, S_SQ1, S_SQ2, S_MULR, S_NORM,
    S_CORD, S_KMUL, S_ASUM, S_AMUL, S_OUT
  } state_t;

  state_t             state_r;
  logic signed [63:0] acc_r;
  logic [IDX_W-1:0]   idx_r;
  logic               last_r;
  logic [63:0]        x_r;
  logic               clamped_r;
  logic [31:0]        r1_r;
  logic [5:0]         e1_r;
  logic [5:0]         e2_r;
  logic [63:0]        w_r;
  logic [4:0]         k_r;
  logic signed [63:0] cx_r;
  logic signed [63:0] cy_r;
  logic signed [63:0] cz_r;
  logic [5:0]         it_r;
  logic               rep_r;
  logic [N_W-1:0]     n_r;
  logic [31:0]        a_r;
  logic [31:0]        inv_r;
  logic [19:0]        eps_r;
  logic               out_valid_r;
  lgd_out_t           out_r;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic [63:0]        mul_p;

  logic               sq_start;
  logic [63:0]        sq_opnd;
  sq_stat_t           sq_stat;
  logic [31:0]        sq_root;
  logic [5:0]         sq_expo;

  logic signed [63:0] term;
  logic signed [64:0] sum65;
  logic signed [63:0] acc_nxt;
  logic signed [63:0] neg;
  logic [63:0]        thr;
  logic               clamp_c;
  logic [63:0]        x_c;
  logic [6:0]         rshift;
  logic [63:0]        w_c;
  logic [38:0]        m_c;
  logic [5:0]         sh;
  logic signed [63:0] dx;
  logic signed [63:0] dy;
  logic signed [63:0] tab;
  logic [29:0]        zpart;
  logic [36:0]        pr;
  logic               out_free;

  lgd_mul u_mul (.clk(clk), .op_a(mul_a), .op_b(mul_b), .prod(mul_p));

  lgd_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .opnd(sq_opnd),
    .stat(sq_stat), .root(sq_root), .expo(sq_expo)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_IDLE: begin
        mul_a = {in_data.u_coord[31], in_data.u_coord};
        mul_b = {in_data.v_coord[31], in_data.v_coord};
      end
      S_SQ2: begin
        mul_a = {1'b0, r1_r};
        mul_b = {1'b0, sq_root};
      end
      S_KMUL: begin
        mul_a = {28'd0, k_r};
        mul_b = {1'b0, LN2_Q27};
      end
      S_AMUL, S_OUT: begin
        mul_a = {1'b0, a_r};
        mul_b = {1'b0, inv_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // saturating accumulate
  always_comb begin
    term  = (idx_r == '0) ? $signed(mul_p) : -$signed(mul_p);
    sum65 = {acc_r[63], acc_r} + {term[63], term};
    if (sum65[64] != sum65[63]) begin
      acc_nxt = sum65[64] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_nxt = sum65[63:0];
    end
  end

  // clamp of the negated inner product
  always_comb begin
    neg     = (acc_r == ACC_MIN) ? ACC_MAX : -acc_r;
    thr     = ONE_Q40 + ({44'd0, eps_r} << 20);
    clamp_c = neg[63] || (neg < $signed(thr));
    x_c     = clamp_c ? thr : neg;
  end

  always_comb begin
    sq_start = 1'b0;
    sq_opnd  = x_c - ONE_Q40;
    if (state_r == S_CLAMP) begin
      sq_start = 1'b1;
    end else if (state_r == S_SQ1) begin
      sq_start = sq_stat.done;
      sq_opnd  = x_r + ONE_Q40;
    end
  end

  always_comb begin
    rshift = 7'd2 + 7'(({1'b0, e1_r} + {1'b0, e2_r}) >> 1);
    w_c    = (x_r >> 2) + (mul_p >> rshift);
    m_c    = w_r[38:0];
    sh     = (it_r > 6'd62) ? 6'd62 : it_r;
    dx     = cy_r >>> sh;
    dy     = cx_r >>> sh;
    tab    = ATANH_TAB[sh];
    zpart  = cz_r[63] ? 30'd0 : 30'(cz_r >>> 34);
    pr     = mul_p[63:27];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      inv_r       <= INV_SQRT_RST;
      eps_r       <= EPS_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_INV_SQRT: inv_r <= cfg_data;
          CFG_EPSILON:  eps_r <= cfg_data[19:0];
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            last_r  <= in_data.last_coord;
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          if (idx_r < IDX_W'(MAX_DIM)) begin
            acc_r <= acc_nxt;
            idx_r <= idx_r + 1'b1;
          end
          state_r <= last_r ? S_CLAMP : S_IDLE;
        end
        S_CLAMP: begin
          x_r       <= x_c;
          clamped_r <= clamp_c;
          acc_r     <= '0;
          idx_r     <= '0;
          state_r   <= S_SQ1;
        end
        S_SQ1: begin
          if (sq_stat.done) begin
            r1_r    <= sq_root;
            e1_r    <= sq_expo;
            state_r <= S_SQ2;
          end
        end
        S_SQ2: begin
          if (sq_stat.done) begin
            e2_r    <= sq_expo;
            state_r <= S_MULR;
          end
        end
        S_MULR: begin
          w_r     <= w_c;
          k_r     <= '0;
          state_r <= S_NORM;
        end
        S_NORM: begin
          if (w_r >= ONE_Q39) begin
            w_r <= w_r >> 1;
            k_r <= k_r + 5'd1;
          end else begin
            cx_r    <= $signed(({25'd0, m_c} + ONE_Q38) << 22);
            cy_r    <= $signed(({25'd0, m_c} - ONE_Q38) << 22);
            cz_r    <= '0;
            it_r    <= 6'd1;
            rep_r   <= 1'b0;
            n_r     <= '0;
            state_r <= S_CORD;
          end
        end
        S_CORD: begin
          if (!cy_r[63]) begin
            cx_r <= cx_r - dx;
            cy_r <= cy_r - dy;
            cz_r <= cz_r + tab;
          end else begin
            cx_r <= cx_r + dx;
            cy_r <= cy_r + dy;
            cz_r <= cz_r - tab;
          end
          if ((it_r == 6'd4 || it_r == 6'd13 || it_r == 6'd40) && !rep_r) begin
            rep_r <= 1'b1;
          end else begin
            it_r  <= it_r + 6'd1;
            rep_r <= 1'b0;
          end
          n_r <= n_r + 1'b1;
          if (n_r == N_W'(CORDIC_ITERATIONS - 1)) begin
            state_r <= S_KMUL;
          end
        end
        S_KMUL: state_r <= S_ASUM;
        S_ASUM: begin
          a_r     <= {2'b00, zpart} + mul_p[31:0];
          state_r <= S_AMUL;
        end
        S_AMUL: state_r <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            out_valid_r       <= 1'b1;
            out_r.was_clamped <= clamped_r;
            if (pr[36:32] != 5'd0) begin
              out_r.distance  <= '1;
              out_r.saturated <= 1'b1;
            end else begin
              out_r.distance  <= pr[31:0];
              out_r.saturated <= 1'b0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- sv/lgd_mul.sv -----
// lgd_mul: shared 33x33 signed multiplier with registered product
`timescale 1ns / 1ps
module lgd_mul (
  input  logic               clk,
  input  logic signed [32:0] op_a,
  input  logic signed [32:0] op_b,
  output logic [63:0]        prod
);
  logic signed [65:0] full;

  assign full = op_a * op_b;

  always_ff @(posedge clk) begin
    prod <= full[63:0];
  end
endmodule

// ----- sv/lgd_sqrt.sv -----
// lgd_sqrt: iterative normalizing integer square root, one step per cycle
`timescale 1ns / 1ps
module lgd_sqrt (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [63:0]          opnd,
  output lgd_pkg::sq_stat_t    stat,
  output logic [31:0]          root,
  output logic [5:0]           expo
);
  import lgd_pkg::*;

  typedef enum logic [1:0] {Q_IDLE, Q_NORM, Q_ROOT} q_state_t;

  q_state_t    state_r;
  logic [63:0] v_r;
  logic [63:0] res_r;
  logic [63:0] bit_r;
  logic [5:0]  s_r;
  logic        done_r;
  logic [63:0] trial;

  assign trial = res_r + bit_r;
  assign stat.busy = (state_r != Q_IDLE);
  assign stat.done = done_r;
  assign root = res_r[31:0];
  assign expo = s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= Q_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        Q_IDLE: begin
          if (start) begin
            v_r     <= opnd;
            s_r     <= '0;
            state_r <= Q_NORM;
          end
        end
        Q_NORM: begin
          if (v_r != 0 && v_r[63:62] == 2'b00 && s_r < 6'd62) begin
            v_r <= v_r << 2;
            s_r <= s_r + 6'd2;
          end else begin
            res_r   <= '0;
            bit_r   <= 64'd1 << 62;
            state_r <= Q_ROOT;
          end
        end
        Q_ROOT: begin
          if (v_r >= trial) begin
            v_r   <= v_r - trial;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r == 64'd1) begin
            done_r  <= 1'b1;
            state_r <= Q_IDLE;
          end
        end
        default: state_r <= Q_IDLE;
      endcase
    end
  end
endmodule

// ----- sv/lgd_checker.sv -----
// lgd_assert: port-level assertions for the lorentz distance block and its bind
`timescale 1ns / 1ps
module lgd_assert (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input lgd_pkg::lgd_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input lgd_pkg::lgd_out_t out_data
);
  import lgd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result payload changed while stalled");

  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |-> out_data.distance == 32'hFFFF_FFFF)
    else $error("saturated flag without full-scale distance");

  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_data.last_coord |=> !$rose(out_valid))
    else $error("result after a non-final pair");
endmodule

bind lorentz_geodesic_distance lgd_assert u_lgd_assert (.*);

// ----- sim/lgd_checker.sv -----
// lgd_checker: predicts lorentz distance results from accepted requests and compares them
`timescale 1ns / 1ps
module lgd_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  lgd_pkg::lgd_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  lgd_pkg::lgd_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data,
  output int                fail_count,
  output int                pending
);
  import lgd_pkg::*;

  logic [63:0] atanh_q62 [63];
  logic [63:0] ln2_q62;
  logic [31:0] inv_sqrt_c;
  logic [19:0] eps;
  logic signed [63:0] minkowski_sum;
  int unsigned coord_count;
  lgd_out_t distance_queue[$];

  assign pending = distance_queue.size();

  initial begin
    logic [63:0] acc, p, sum;
    for (int i = 1; i < 63; i++) begin
      acc = 0;
      for (int k = 0; i * (2 * k + 1) <= 62; k++)
        acc += (64'd1 << (62 - i * (2 * k + 1))) / (2 * k + 1);
      atanh_q62[i] = acc;
    end
    atanh_q62[0] = 0;
    p = (64'd1 << 62) / 3;
    sum = 0;
    for (int k = 0; p != 0; k++) begin
      sum += p / (2 * k + 1);
      p /= 9;
    end
    ln2_q62 = sum << 1;
  end

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] norm_sqrt(input logic [63:0] v, output int e);
    int s;
    s = 0;
    while (v != 0 && v < (64'd1 << 62) && s < 62) begin
      v <<= 2;
      s += 2;
    end
    e = s;
    return floor_sqrt(v);
  endfunction

  function automatic lgd_out_t predict_distance(input logic signed [63:0] acc);
    lgd_out_t r;
    logic [63:0] thr, x, t, r1, r2, s38, w, m, a;
    logic [127:0] prod;
    logic signed [63:0] neg, cx, cy, cz, dx, dy;
    int e1, e2, k, i, sh;
    bit rep;
    thr = ONE_Q40 + (64'(eps) << 20);
    neg = (acc == ACC_MIN) ? ACC_MAX : -acc;
    r.was_clamped = 0;
    if (neg < 0 || 64'(neg) < thr) begin
      x = thr;
      r.was_clamped = 1;
    end else begin
      x = neg;
    end
    t = x - ONE_Q40;
    r1 = norm_sqrt(t, e1);
    r2 = norm_sqrt(t + 2 * ONE_Q40, e2);
    s38 = (r1 * r2) >> (2 + (e1 + e2) / 2);
    w = (x >> 2) + s38;
    k = 0;
    while ((w >> k) >= 2 * ONE_Q38) k++;
    m = w >> k;
    cx = (m + ONE_Q38) << 22;
    cy = (m - ONE_Q38) << 22;
    cz = 0;
    i = 1;
    rep = 0;
    for (int n = 0; n < CORDIC_ITERATIONS; n++) begin
      sh = i > 62 ? 62 : i;
      dx = cy >>> sh;
      dy = cx >>> sh;
      if (cy >= 0) begin
        cx -= dx; cy -= dy; cz += atanh_q62[sh];
      end else begin
        cx += dx; cy += dy; cz -= atanh_q62[sh];
      end
      if ((i == 4 || i == 13 || i == 40) && !rep) rep = 1;
      else begin
        i++;
        rep = 0;
      end
    end
    a = (cz < 0 ? 64'd0 : 64'(cz) >> 34) + 64'(k) * (ln2_q62 >> 35);
    prod = (128'(a) * 128'(inv_sqrt_c)) >> 27;
    if (prod > 128'hFFFFFFFF) begin
      r.distance = '1;
      r.saturated = 1;
    end else begin
      r.distance = prod[31:0];
      r.saturated = 0;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(ACC_MAX)) return ACC_MAX;
    if (s < 65'(ACC_MIN)) return ACC_MIN;
    return s[63:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  always @(posedge clk) begin
    logic signed [63:0] p;
    lgd_out_t want;
    if (!rst_n) begin
      inv_sqrt_c <= INV_SQRT_RST;
      eps <= EPS_RST;
      minkowski_sum <= 0;
      coord_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_INV_SQRT) inv_sqrt_c <= cfg_data;
        else eps <= cfg_data[19:0];
      end
      if (in_valid && !in_stall) begin
        p = 64'(in_data.u_coord) * 64'(in_data.v_coord);
        if (in_data.last_coord) begin
          distance_queue.push_back(predict_distance(coord_count < MAX_DIM ?
            sat_add(minkowski_sum, coord_count == 0 ? p : -p) : minkowski_sum));
          minkowski_sum <= 0;
          coord_count <= 0;
        end else if (coord_count < MAX_DIM) begin
          minkowski_sum <= sat_add(minkowski_sum, coord_count == 0 ? p : -p);
          coord_count <= coord_count + 1;
        end
      end
      if (out_valid && !out_stall) begin
        if (distance_queue.size() == 0) begin
          report_mismatch("unexpected result", out_data.distance, 0);
        end else begin
          want = distance_queue.pop_front();
          if (out_data.distance !== want.distance)
            report_mismatch("distance", out_data.distance, want.distance);
          if (out_data.was_clamped !== want.was_clamped)
            report_mismatch("was_clamped", out_data.was_clamped, want.was_clamped);
          if (out_data.saturated !== want.saturated)
            report_mismatch("saturated", out_data.saturated, want.saturated);
        end
      end
    end
  end

  initial fail_count = 0;
endmodule

// ----- sim/lorentz_geodesic_distance_tb.sv -----
// lorentz_geodesic_distance_tb: stimulus, configuration phases and verdict for the distance block
`timescale 1ns / 1ps
module lorentz_geodesic_distance_tb;
  import lgd_pkg::*;

  localparam int WATCHDOG = 20000;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  lgd_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  lgd_out_t out_data;
  logic cfg_we = 0;
  logic cfg_index = CFG_INV_SQRT;
  logic [31:0] cfg_data = '0;
  int fail_count, pending;
  int idle_cycles = 0;
  bit calm = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  lorentz_geodesic_distance uut (.*);
  lgd_checker chk (.*);

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver stalls in bursts
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 12);
        out_stall <= 1;
        repeat (n) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [31:0] value);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic send_pair(input logic [31:0] u, input logic [31:0] v, input logic last);
    in_valid <= 1;
    in_data <= '{u_coord: u, v_coord: v, last_coord: last};
    do @(posedge clk); while (in_stall);
    in_valid <= 0;
    if (!calm && $urandom_range(0, 6) == 0)
      repeat ($urandom_range(1, 12)) @(posedge clk);
    else
      @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(input int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      default: return 32'($urandom_range(0, 1 << 24));
    endcase
  endfunction

  // hyperboloid-like vector: time part large, space parts moderate (mode 0: all random)
  task automatic send_vector(input int dims, input int mode);
    for (int i = 0; i < dims; i++) begin
      if (i == 0 && mode != 0)
        send_pair(32'h0010_0000 + $urandom_range(0, 1 << 26),
                  32'h0010_0000 + $urandom_range(0, 1 << 26), dims == 1);
      else
        send_pair(rand_coord(mode), rand_coord(mode), i == dims - 1);
    end
  endtask

  initial begin
    int dims;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, single pair, overflow, clamp, too many coordinates
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
    send_pair(32'h8000_0000, 32'h8000_0000, 1);
    send_pair(32'h8000_0000, 32'h7FFF_FFFF, 1);
    send_pair(0, 0, 1);
    send_pair(32'h0010_0000, 32'h0010_0000, 1);
    send_pair(32'h0020_0000, 32'h0020_0000, 0);
    send_pair(32'h0010_0000, 32'h0010_0000, 1);
    send_pair(0, 0, 0);
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send_pair(32'h8000_0000, 32'h7FFF_FFFF, 1);
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send_pair(32'h7FFF_FFFF, 32'h8000_0000, 1);
    send_pair(32'h7FFF_FFFF, 32'h8000_0000, 0);
    send_pair(32'h8000_0000, 32'h8000_0000, 1);
    for (int i = 0; i < MAX_DIM + 4; i++)
      send_pair(32'h0100_0000, 32'h0000_1000, i == MAX_DIM + 3);
    drain();

    write_reg(CFG_INV_SQRT, 32'hFFFF_FFFF);
    write_reg(CFG_EPSILON, 32'h000F_FFFF);
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
    send_pair(0, 0, 1);
    send_pair(32'h0400_0000, 32'h0400_0000, 1);
    drain();
    write_reg(CFG_INV_SQRT, 0);
    write_reg(CFG_EPSILON, 0);
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
    send_pair(32'h0010_0000, 32'h0010_0000, 1);
    drain();

    // random phases with different settings
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(CFG_INV_SQRT, phase == 0 ? INV_SQRT_RST : $urandom);
      write_reg(CFG_EPSILON, phase == 1 ? 32'h000F_FFFF : $urandom_range(0, 2000));
      calm = (phase == 5);
      for (int items = 0; items < 330; items += dims) begin
        dims = $urandom_range(0, 9) == 0 ? $urandom_range(1, 70) : $urandom_range(1, 6);
        send_vector(dims, $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 2));
      end
      drain();
    end

    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
